### rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SFMT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sfmt check failed");

// Check a property on every clock edge, reset included.
`define SFMT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sfmt check failed around reset");

`endif

### rtl/sfmt_pkg.sv
`timescale 1ns / 1ps
package sfmt_pkg;

  localparam int MAG_W         = 32;
  localparam int DIGIT_W       = 4;
  localparam int NUM_DIGITS    = 10;
  localparam int BCD_W         = NUM_DIGITS * DIGIT_W;
  localparam int BITS_PER_STEP = 4;
  localparam int STEPS         = MAG_W / BITS_PER_STEP;
  localparam int STEP_CNT_W    = $clog2(STEPS);
  localparam int DIGIT_IDX_W   = $clog2(NUM_DIGITS);
  localparam int CHAR_W        = 6;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 6'd57;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

  localparam logic [DIGIT_W-1:0] DIGIT_FIVE  = 4'd5;
  localparam logic [DIGIT_W-1:0] DIGIT_THREE = 4'd3;

  typedef struct packed {
    logic             neg;
    logic [BCD_W-1:0] bcd;
  } entry_t;

  // Shift-add-3: fold the next BITS_PER_STEP magnitude bits, MSB first, into the BCD word.
  function automatic logic [BCD_W-1:0] dabble_step(
    input logic [BCD_W-1:0]         bcd_in,
    input logic [BITS_PER_STEP-1:0] bits
  );
    logic [BCD_W-1:0] r;
    r = bcd_in;
    for (int b = BITS_PER_STEP - 1; b >= 0; b--) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (r[d*DIGIT_W +: DIGIT_W] >= DIGIT_FIVE) begin
          r[d*DIGIT_W +: DIGIT_W] = r[d*DIGIT_W +: DIGIT_W] + DIGIT_THREE;
        end
      end
      r = {r[BCD_W-2:0], bits[b]};
    end
    return r;
  endfunction

endpackage

### rtl/signed_decimal_ascii_formatter_unit.sv
`timescale 1ns / 1ps
// Channel  Dir  Data                          Flags
// s_*      in   tdata[31:0] value (signed)    -
// m_*      out  tdata[5:0] character, 7:6 0   tlast = last character of a value
//
// Front: accept, then 8 shift-add-3 steps of 4 bits, then hand off to the queue.
// Back: load, then one beat per cycle while m_tready is high, 1 to 11 beats per value.
// The QUEUE_DEPTH entry queue lets the front convert the next value
// while the back waits on m_tready.
// Reset: synchronous; no clearing pass.
module signed_decimal_ascii_formatter_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [5:0] character, [7:6] zero
  output logic        m_tlast
);
  import sfmt_pkg::*;

  entry_t push_entry;
  entry_t pop_entry;
  logic   push;
  logic   pop;
  logic   full;
  logic   empty;

  sfmt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .push       (push),
    .push_entry (push_entry),
    .full       (full)
  );

  sfmt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .empty      (empty)
  );

  sfmt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop       (pop),
    .pop_entry (pop_entry),
    .empty     (empty),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

### rtl/sfmt_front.sv
`timescale 1ns / 1ps
module sfmt_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [31:0]           s_tdata,
  output logic                  push,
  output sfmt_pkg::entry_t      push_entry,
  input  logic                  full
);
  import sfmt_pkg::*;

  typedef enum logic [2:0] {
    IDLE = 3'b001,
    CONV = 3'b010,
    DONE = 3'b100
  } front_state_t;

  front_state_t          state;
  logic [STEP_CNT_W-1:0] step_cnt;
  logic [MAG_W-1:0]      mag;
  logic [BCD_W-1:0]      bcd;
  logic                  neg;

  assign s_tready         = (state == IDLE);
  assign push             = (state == DONE) && !full;
  assign push_entry.neg   = neg;
  assign push_entry.bcd   = bcd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      step_cnt <= '0;
    end else begin
      case (state)
        IDLE: begin
          step_cnt <= '0;
          if (s_tvalid) begin
            state <= CONV;
          end
        end
        CONV: begin
          step_cnt <= step_cnt + 1'b1;
          if (step_cnt == STEP_CNT_W'(STEPS - 1)) begin
            state <= DONE;
          end
        end
        DONE: begin
          if (!full) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      neg <= s_tdata[MAG_W-1];
      mag <= s_tdata[MAG_W-1] ? (~s_tdata + 32'd1) : s_tdata;
      bcd <= '0;
    end else if (state == CONV) begin
      bcd <= dabble_step(bcd, mag[MAG_W-1 -: BITS_PER_STEP]);
      mag <= {mag[MAG_W-BITS_PER_STEP-1:0], {BITS_PER_STEP{1'b0}}};
    end
  end

endmodule

### rtl/sfmt_queue.sv
`timescale 1ns / 1ps
module sfmt_queue #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sfmt_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output sfmt_pkg::entry_t pop_entry,
  output logic             empty
);
  import sfmt_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);
  assign pop_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_entry;
    end
  end

endmodule

### rtl/sfmt_back.sv
`timescale 1ns / 1ps
module sfmt_back (
  input  logic             clk,
  input  logic             rst,
  output logic             pop,
  input  sfmt_pkg::entry_t pop_entry,
  input  logic             empty,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,
  output logic             m_tlast
);
  import sfmt_pkg::*;

  logic                   active;
  logic                   sign_pending;
  logic [BCD_W-1:0]       bcd;
  logic [DIGIT_IDX_W-1:0] idx;
  logic [DIGIT_IDX_W-1:0] msd_idx;
  logic [DIGIT_W-1:0]     digit;
  logic [CHAR_W-1:0]      character;

  always_comb begin
    msd_idx = '0;
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (pop_entry.bcd[d*DIGIT_W +: DIGIT_W] != '0) begin
        msd_idx = DIGIT_IDX_W'(d);
      end
    end
  end

  assign pop       = !active && !empty;
  assign digit     = bcd[idx*DIGIT_W +: DIGIT_W];
  assign character = sign_pending ? CHAR_MINUS : CHAR_ZERO + {2'b00, digit};
  assign m_tvalid  = active;
  assign m_tdata   = {{(8 - CHAR_W){1'b0}}, character};
  assign m_tlast   = !sign_pending && (idx == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (pop) begin
      active <= 1'b1;
    end else if (m_tvalid && m_tready && m_tlast) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      sign_pending <= pop_entry.neg;
      bcd          <= pop_entry.bcd;
      idx          <= msd_idx;
    end else if (m_tvalid && m_tready) begin
      if (sign_pending) begin
        sign_pending <= 1'b0;
      end else if (idx != '0) begin
        idx <= idx - 1'b1;
      end
    end
  end

endmodule

### rtl/sfmt_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sfmt_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [31:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic        m_tlast
);
  import sfmt_pkg::*;

  logic m_stall;
  logic is_minus;
  logic is_digit;

  assign m_stall  = m_tvalid && !m_tready;
  assign is_minus = (m_tdata[5:0] == CHAR_MINUS);
  assign is_digit = (m_tdata[5:0] >= CHAR_ZERO) && (m_tdata[5:0] <= CHAR_NINE);

  `SFMT_ASSERT(a_out_hold, m_stall |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
  `SFMT_ASSERT(a_char_range, m_tvalid |-> m_tdata[7:6] == 2'b00 && (is_minus || is_digit))
  `SFMT_ASSERT(a_minus_not_last, m_tvalid && is_minus |-> !m_tlast)
  `SFMT_ASSERT(a_minus_then_digit, m_tvalid && m_tready && is_minus |=> m_tvalid && is_digit && m_tdata[5:0] != CHAR_ZERO)
  `SFMT_ASSERT_ALWAYS(a_reset_quiet, rst |=> !m_tvalid)

endmodule

bind signed_decimal_ascii_formatter_unit sfmt_checker u_sfmt_checker (.*);
